// ===== hdl/assert_macros.svh =====
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent check on the rising edge of clk, idle while rst_n is low.
`define CDQ_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Concurrent check that also holds during reset.
`define CDQ_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== hdl/cdq_pkg.sv =====
`timescale 1ns / 1ps

package cdq_pkg;

  localparam int DEPTH  = 16;
  localparam int DATA_W = 32;
  localparam int IDX_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CAP_W  = $clog2(DEPTH + 1) + 1;
  localparam int CFG_W  = 5;
  localparam int CMD_W  = 3;
  localparam int STAT_W = 2;

  localparam logic [CMD_W-1:0] CMD_PUSH_FRONT = 3'd0;
  localparam logic [CMD_W-1:0] CMD_PUSH_BACK  = 3'd1;
  localparam logic [CMD_W-1:0] CMD_POP_FRONT  = 3'd2;
  localparam logic [CMD_W-1:0] CMD_POP_BACK   = 3'd3;
  localparam logic [CMD_W-1:0] CMD_PEEK       = 3'd4;

  localparam logic [STAT_W-1:0] STAT_DONE  = 2'd0;
  localparam logic [STAT_W-1:0] STAT_FULL  = 2'd1;
  localparam logic [STAT_W-1:0] STAT_EMPTY = 2'd2;

  typedef struct packed {
    logic load;
    logic exec;
    logic read;
  } cdq_ctrl_t;

endpackage

// ===== hdl/cdq_ctrl.sv =====
`timescale 1ns / 1ps

module cdq_ctrl
  import cdq_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  output logic      out_valid,
  input  logic      out_ready,
  output cdq_ctrl_t ctrl
);

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_EXEC = 4'b0010,
    S_READ = 4'b0100,
    S_RESP = 4'b1000
  } state_t;

  state_t state_r, state_nxt;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_valid) state_nxt = S_EXEC;
      end
      S_EXEC: state_nxt = S_READ;
      S_READ: state_nxt = S_RESP;
      S_RESP: begin
        if (out_ready) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = (state_r == S_RESP);
  assign ctrl.load = (state_r == S_IDLE) && in_valid;
  assign ctrl.exec = (state_r == S_EXEC);
  assign ctrl.read = (state_r == S_READ);

endmodule

// ===== hdl/cdq_datapath.sv =====
`timescale 1ns / 1ps

module cdq_datapath
  import cdq_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst_n,
  input  cdq_ctrl_t                ctrl,
  input  logic                     cfg_we,
  input  logic [CFG_W-1:0]         cfg_wdata,
  input  logic [CMD_W-1:0]         in_command,
  input  logic signed [DATA_W-1:0] in_value,
  output logic [STAT_W-1:0]        out_status,
  output logic signed [DATA_W-1:0] out_front_value,
  output logic signed [DATA_W-1:0] out_rear_value,
  output logic                     out_is_empty,
  output logic                     out_is_full
);

  logic [DATA_W-1:0] ring_mem [DEPTH];

  logic [CAP_W-1:0]  capacity_r, capacity_nxt;
  logic [IDX_W-1:0]  head_r, head_nxt;
  logic [IDX_W-1:0]  tail_r, tail_nxt;
  logic              empty_r, empty_nxt;
  logic [CMD_W-1:0]  cmd_r;
  logic [DATA_W-1:0] value_r;
  logic [STAT_W-1:0] status_r, status_nxt;
  logic [DATA_W-1:0] rd_front_r;
  logic [DATA_W-1:0] rd_rear_r;
  logic              wr_en;
  logic [IDX_W-1:0]  wr_addr;
  logic              full;
  logic              is_push;
  logic              is_pop;

  function automatic logic [IDX_W-1:0] step_up(input logic [IDX_W-1:0] i,
                                               input logic [CAP_W-1:0] cap);
    logic [CAP_W-1:0] n;
    n = CAP_W'(i) + 1'b1;
    return (n >= cap) ? '0 : IDX_W'(n);
  endfunction

  function automatic logic [IDX_W-1:0] step_down(input logic [IDX_W-1:0] i,
                                                 input logic [CAP_W-1:0] cap);
    return (i == '0) ? IDX_W'(cap - 1'b1) : i - 1'b1;
  endfunction

  assign full    = !empty_r && (step_up(tail_r, capacity_r) == head_r);
  assign is_push = cmd_r inside {CMD_PUSH_FRONT, CMD_PUSH_BACK};
  assign is_pop  = cmd_r inside {CMD_POP_FRONT, CMD_POP_BACK};

  always_comb begin
    capacity_nxt = capacity_r;
    if (cfg_wdata == '0) begin
      capacity_nxt = CAP_W'(1);
    end else if (int'(cfg_wdata) > DEPTH) begin
      capacity_nxt = CAP_W'(DEPTH);
    end else begin
      capacity_nxt = CAP_W'(cfg_wdata);
    end
  end

  always_comb begin
    head_nxt   = head_r;
    tail_nxt   = tail_r;
    empty_nxt  = empty_r;
    status_nxt = STAT_DONE;
    wr_en      = 1'b0;
    wr_addr    = '0;
    if (is_push) begin
      if (full) begin
        status_nxt = STAT_FULL;
      end else if (empty_r) begin
        head_nxt  = '0;
        tail_nxt  = '0;
        empty_nxt = 1'b0;
        wr_en     = 1'b1;
        wr_addr   = '0;
      end else if (cmd_r == CMD_PUSH_FRONT) begin
        head_nxt = step_down(head_r, capacity_r);
        wr_en    = 1'b1;
        wr_addr  = head_nxt;
      end else begin
        tail_nxt = step_up(tail_r, capacity_r);
        wr_en    = 1'b1;
        wr_addr  = tail_nxt;
      end
    end else if (is_pop) begin
      if (empty_r) begin
        status_nxt = STAT_EMPTY;
      end else if (head_r == tail_r) begin
        head_nxt  = '0;
        tail_nxt  = '0;
        empty_nxt = 1'b1;
      end else if (cmd_r == CMD_POP_FRONT) begin
        head_nxt = step_up(head_r, capacity_r);
      end else begin
        tail_nxt = step_down(tail_r, capacity_r);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      capacity_r <= CAP_W'(DEPTH);
      head_r     <= '0;
      tail_r     <= '0;
      empty_r    <= 1'b1;
    end else if (cfg_we) begin
      capacity_r <= capacity_nxt;
      head_r     <= '0;
      tail_r     <= '0;
      empty_r    <= 1'b1;
    end else if (ctrl.exec) begin
      head_r  <= head_nxt;
      tail_r  <= tail_nxt;
      empty_r <= empty_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      cmd_r   <= in_command;
      value_r <= in_value;
    end
    if (ctrl.exec) begin
      status_r <= status_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.exec && wr_en) begin
      ring_mem[wr_addr] <= value_r;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.read) begin
      rd_front_r <= ring_mem[head_r];
      rd_rear_r  <= ring_mem[tail_r];
    end
  end

  assign out_status      = status_r;
  assign out_front_value = empty_r ? '1 : rd_front_r;
  assign out_rear_value  = empty_r ? '1 : rd_rear_r;
  assign out_is_empty    = empty_r;
  assign out_is_full     = full;

endmodule

// ===== hdl/circular_deque_core.sv =====
// Channel  Direction  Handshake             Payload
// in       input      in_valid / in_ready   in_command, in_value
// out      output     out_valid / out_ready out_status, out_front_value, out_rear_value,
//                                           out_is_empty, out_is_full
// cfg      input      cfg_we                cfg_wdata
//
// Each item waits in the respond step for as long as out_ready is low.
// The sequencer steps through: update pointers and write the ring, read the ring, respond.
// A new item is accepted only once the previous result has gone.
// Reset empties the deque and sets the capacity to its full depth; no clearing pass is needed.
// While a result waits for out_ready, no new item is accepted.
`timescale 1ns / 1ps

`include "assert_macros.svh"

module circular_deque_core
  import cdq_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  logic [CMD_W-1:0]         in_command,
  input  logic signed [DATA_W-1:0] in_value,
  output logic                     out_valid,
  input  logic                     out_ready,
  output logic [STAT_W-1:0]        out_status,
  output logic signed [DATA_W-1:0] out_front_value,
  output logic signed [DATA_W-1:0] out_rear_value,
  output logic                     out_is_empty,
  output logic                     out_is_full,
  input  logic                     cfg_we,
  input  logic [CFG_W-1:0]         cfg_wdata
);

  cdq_ctrl_t ctrl;

  cdq_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .ctrl      (ctrl)
  );

  cdq_datapath u_datapath (
    .clk             (clk),
    .rst_n           (rst_n),
    .ctrl            (ctrl),
    .cfg_we          (cfg_we),
    .cfg_wdata       (cfg_wdata),
    .in_command      (in_command),
    .in_value        (in_value),
    .out_status      (out_status),
    .out_front_value (out_front_value),
    .out_rear_value  (out_rear_value),
    .out_is_empty    (out_is_empty),
    .out_is_full     (out_is_full)
  );

  `CDQ_ASSERT(a_ready_valid_excl, !(in_ready && out_valid), "ready and valid both high")
  `CDQ_ASSERT(a_accept_blocks, (in_valid && in_ready) |=> !in_ready, "second item accepted")
  `CDQ_ASSERT(a_empty_value, (out_valid && out_is_empty) |-> (out_front_value == -1), "bad empty")
  `CDQ_ASSERT(a_full_not_empty, out_is_full |-> !out_is_empty, "full and empty together")

endmodule

// ===== tb/tb_circular_deque_core.sv =====
`timescale 1ns / 1ps

module tb_circular_deque_core;
  import cdq_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 300000;
  localparam int unsigned RANDOM_PHASES = 10;
  localparam int unsigned PRINT_LIMIT = 40;

  typedef struct packed {
    logic [CMD_W-1:0]         cmd;
    logic signed [DATA_W-1:0] word;
  } deque_cmd_t;

  typedef struct packed {
    logic [STAT_W-1:0]        status;
    logic signed [DATA_W-1:0] front;
    logic signed [DATA_W-1:0] rear;
    logic                     empty;
    logic                     full;
  } deque_view_t;

  logic                     clk;
  logic                     rst_n = 1'b0;
  logic                     in_valid = 1'b0;
  logic                     in_ready;
  logic [CMD_W-1:0]         in_command = CMD_PEEK;
  logic signed [DATA_W-1:0] in_value = '0;
  logic                     out_valid;
  logic                     out_ready = 1'b0;
  logic [STAT_W-1:0]        out_status;
  logic signed [DATA_W-1:0] out_front_value;
  logic signed [DATA_W-1:0] out_rear_value;
  logic                     out_is_empty;
  logic                     out_is_full;
  logic                     cfg_we = 1'b0;
  logic [CFG_W-1:0]         cfg_wdata = '0;

  circular_deque_core dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_command      (in_command),
    .in_value        (in_value),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_status      (out_status),
    .out_front_value (out_front_value),
    .out_rear_value  (out_rear_value),
    .out_is_empty    (out_is_empty),
    .out_is_full     (out_is_full),
    .cfg_we          (cfg_we),
    .cfg_wdata       (cfg_wdata)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  deque_cmd_t  commands_to_send[$];
  deque_view_t deque_views_due[$];
  int unsigned queued_total = 0;
  int unsigned accepted_total = 0;
  int unsigned mismatches = 0;
  int unsigned cycle_count = 0;
  logic        in_taken = 1'b0;

  // Shadow copy of the deque state.
  logic signed [DATA_W-1:0] ring_mem [DEPTH];
  int unsigned              head_at;
  int unsigned              tail_at;
  bit                       ring_empty;
  int unsigned              ring_cap;

  function automatic int unsigned ring_next(int unsigned i);
    return (i + 1 >= ring_cap) ? 0 : i + 1;
  endfunction

  function automatic int unsigned ring_prev(int unsigned i);
    return (i == 0) ? ring_cap - 1 : i - 1;
  endfunction

  function automatic bit ring_full();
    return !ring_empty && ring_next(tail_at) == head_at;
  endfunction

  function automatic void empty_ring();
    head_at = 0;
    tail_at = 0;
    ring_empty = 1'b1;
  endfunction

  function automatic void apply_capacity(logic [CFG_W-1:0] wdata);
    if (wdata < 1) begin
      ring_cap = 1;
    end else if (wdata > DEPTH) begin
      ring_cap = DEPTH;
    end else begin
      ring_cap = 32'(wdata);
    end
    empty_ring();
  endfunction

  function automatic deque_view_t advance_deque(logic [CMD_W-1:0] cmd,
                                                logic signed [DATA_W-1:0] word);
    deque_view_t view;
    view.status = STAT_DONE;
    case (cmd)
      CMD_PUSH_FRONT, CMD_PUSH_BACK: begin
        if (ring_full()) begin
          view.status = STAT_FULL;
        end else if (ring_empty) begin
          head_at = 0;
          tail_at = 0;
          ring_mem[0] = word;
          ring_empty = 1'b0;
        end else if (cmd == CMD_PUSH_FRONT) begin
          head_at = ring_prev(head_at);
          ring_mem[head_at] = word;
        end else begin
          tail_at = ring_next(tail_at);
          ring_mem[tail_at] = word;
        end
      end
      CMD_POP_FRONT, CMD_POP_BACK: begin
        if (ring_empty) begin
          view.status = STAT_EMPTY;
        end else if (head_at == tail_at) begin
          empty_ring();
        end else if (cmd == CMD_POP_FRONT) begin
          head_at = ring_next(head_at);
        end else begin
          tail_at = ring_prev(tail_at);
        end
      end
      default: begin
      end
    endcase
    view.front = ring_empty ? -1 : ring_mem[head_at];
    view.rear = ring_empty ? -1 : ring_mem[tail_at];
    view.empty = ring_empty;
    view.full = ring_full();
    return view;
  endfunction

  task automatic flag_error(string msg);
    mismatches++;
    if (mismatches <= PRINT_LIMIT) begin
      $display("%0t ns: %s", $time, msg);
    end
  endtask

  task automatic queue_item(logic [CMD_W-1:0] cmd, logic signed [DATA_W-1:0] word);
    deque_cmd_t item;
    item.cmd = cmd;
    item.word = word;
    commands_to_send = {commands_to_send, item};
    queued_total++;
  endtask

  task automatic wait_drained();
    while (accepted_total != queued_total || deque_views_due.size() != 0) begin
      @(negedge clk);
    end
  endtask

  task automatic set_capacity(logic [CFG_W-1:0] wdata);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= wdata;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  function automatic logic signed [DATA_W-1:0] random_word();
    case ($urandom_range(0, 31))
      0: return {1'b1, {(DATA_W - 1){1'b0}}};
      1: return {1'b0, {(DATA_W - 1){1'b1}}};
      2: return '0;
      3: return '1;
      default: return $urandom;
    endcase
  endfunction

  // Sender: bursts of random length separated by random gaps.
  int unsigned burst_left = 0;
  int unsigned gap_left = 0;

  always @(negedge clk) begin : send_items
    deque_cmd_t item;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_taken) begin
      if (gap_left != 0) begin
        gap_left--;
        in_valid <= 1'b0;
      end else if (commands_to_send.size() != 0) begin
        item = commands_to_send[0];
        commands_to_send.delete(0);
        in_valid <= 1'b1;
        in_command <= item.cmd;
        in_value <= item.word;
        if (burst_left != 0) begin
          burst_left--;
        end else begin
          burst_left = $urandom_range(0, 30);
          gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
        end
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Receiver: out_ready follows a stall pattern picked at random: always ready, random, or periodic.
  int unsigned ready_tick = 0;
  int unsigned ready_mode = 0;

  always @(negedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      ready_tick++;
      if (ready_tick % 64 == 0) begin
        ready_mode = $urandom_range(0, 2);
      end
      case (ready_mode)
        0: out_ready <= 1'b1;
        1: out_ready <= ($urandom_range(0, 2) != 0);
        default: out_ready <= (ready_tick % 16 >= 11);
      endcase
    end
  end

  always @(posedge clk) begin : sample
    deque_view_t want;
    cycle_count++;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end else if (!rst_n) begin
      in_taken <= 1'b0;
      ring_cap = DEPTH;
      empty_ring();
    end else begin
      if (cfg_we) begin
        apply_capacity(cfg_wdata);
      end
      in_taken <= in_valid && in_ready;
      if (in_valid && in_ready) begin
        deque_views_due = {deque_views_due, advance_deque(in_command, in_value)};
        accepted_total++;
      end
      if (out_valid && out_ready) begin
        if (deque_views_due.size() == 0) begin
          flag_error("Result arrived with no item outstanding.");
        end else begin
          want = deque_views_due[0];
          deque_views_due.delete(0);
          if (out_status !== want.status) begin
            flag_error($sformatf("status %0d, expected %0d", out_status, want.status));
          end
          if (out_front_value !== want.front) begin
            flag_error($sformatf("front %0d, expected %0d", out_front_value, want.front));
          end
          if (out_rear_value !== want.rear) begin
            flag_error($sformatf("rear %0d, expected %0d", out_rear_value, want.rear));
          end
          if (out_is_empty !== want.empty) begin
            flag_error($sformatf("empty %b, expected %b", out_is_empty, want.empty));
          end
          if (out_is_full !== want.full) begin
            flag_error($sformatf("full %b, expected %b", out_is_full, want.full));
          end
        end
      end
    end
  end

  initial begin : stimulus
    int unsigned      phase_len;
    int unsigned      run_left;
    int unsigned      roll;
    bit               fill_bias;
    logic [CFG_W-1:0] cap_word;
    logic [CMD_W-1:0] cmd;
    repeat (12) @(negedge clk);
    rst_n <= 1'b1;

    // Reset capacity: pops and peeks on an empty deque, extreme values, unused codes.
    queue_item(CMD_PEEK, random_word());
    queue_item(CMD_POP_FRONT, random_word());
    queue_item(CMD_POP_BACK, random_word());
    queue_item(CMD_PEEK + 3'd3, random_word());
    queue_item(CMD_PUSH_BACK, {1'b0, {(DATA_W - 1){1'b1}}});
    queue_item(CMD_PUSH_FRONT, {1'b1, {(DATA_W - 1){1'b0}}});
    queue_item(CMD_PEEK, '0);
    queue_item(CMD_POP_BACK, '0);
    queue_item(CMD_POP_FRONT, '0);
    queue_item(CMD_PEEK + 3'd1, '1);
    queue_item(CMD_PEEK + 3'd2, '1);
    wait_drained();

    // Small ring: fill it, refuse pushes at both ends, drain it past empty.
    set_capacity(3);
    queue_item(CMD_PUSH_FRONT, '1);
    queue_item(CMD_PUSH_BACK, '0);
    queue_item(CMD_PUSH_FRONT, 1);
    queue_item(CMD_PUSH_BACK, 2);
    queue_item(CMD_PUSH_FRONT, 3);
    queue_item(CMD_POP_BACK, '0);
    queue_item(CMD_POP_FRONT, '0);
    queue_item(CMD_PUSH_BACK, 32'sh5555_5555);
    queue_item(CMD_POP_FRONT, '0);
    queue_item(CMD_POP_BACK, '0);
    queue_item(CMD_POP_BACK, '0);
    queue_item(CMD_POP_FRONT, '0);

    for (int p = 0; p < RANDOM_PHASES; p++) begin
      wait_drained();
      case (p)
        0: cap_word = '0;
        1: cap_word = '1;
        2: cap_word = 2;
        3: cap_word = DEPTH + 1;
        4: cap_word = 1;
        5: cap_word = DEPTH;
        default: cap_word = $urandom_range(1, DEPTH - 1);
      endcase
      set_capacity(cap_word);
      phase_len = $urandom_range(90, 120);
      fill_bias = 1'b0;
      run_left = 0;
      for (int n = 0; n < phase_len; n++) begin
        if (run_left == 0) begin
          fill_bias = !fill_bias;
          run_left = $urandom_range(4, 40);
        end
        run_left--;
        roll = $urandom_range(0, 99);
        if (roll < 2) begin
          cmd = CMD_PEEK;
        end else if (roll < 5) begin
          cmd = CMD_W'($urandom_range(CMD_PEEK + 1, (1 << CMD_W) - 1));
        end else if ((roll < 75) == fill_bias) begin
          cmd = $urandom_range(0, 1) ? CMD_PUSH_BACK : CMD_PUSH_FRONT;
        end else begin
          cmd = $urandom_range(0, 1) ? CMD_POP_BACK : CMD_POP_FRONT;
        end
        queue_item(cmd, random_word());
      end
    end

    wait_drained();
    repeat (20) @(posedge clk);
    if (mismatches == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
